/* rtl/core/text_console_page_renderer_assert.svh */
// Assertion macros for the text console page renderer.
// Used by modules that include this header; no other dependencies.
`ifndef TEXT_CONSOLE_PAGE_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_PAGE_RENDERER_ASSERT_SVH

// Same-cycle implication.
`define TCPR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcpr assertion failed");

// Next-cycle implication.
`define TCPR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcpr assertion failed");

`endif

/* rtl/core/tcpr_pkg.sv */
// Package for the text console page renderer: sizes, codes, item types,
// memory request struct, glyph ROM and address helpers. No dependencies.
`default_nettype none

package tcpr_pkg;

  localparam int PAGES       = 8;
  localparam int COLUMNS     = 128;
  localparam int GLYPH_WIDTH = 8;

  localparam int STORE_BYTES = PAGES * COLUMNS;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PAGE_W      = $clog2(PAGES + 1);
  localparam int COL_W       = $clog2(COLUMNS + 1);
  localparam int GK_W        = $clog2(GLYPH_WIDTH);

  localparam int FIRST_GLYPH  = 32;
  localparam int END_GLYPH    = 126;
  localparam int GLYPH_COUNT  = END_GLYPH - FIRST_GLYPH;
  localparam int GLYPH_IDX_W  = $clog2(GLYPH_COUNT);
  localparam int TAB_STEP     = 16;
  localparam int CODE_NEWLINE = 10;
  localparam int CODE_TAB     = 9;

  localparam logic [1:0] FUNC_PRINT  = 2'd0;
  localparam logic [1:0] FUNC_FILL   = 2'd1;
  localparam logic [1:0] FUNC_REWIND = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [1:0] PEN_ONES   = 2'd0;
  localparam logic [1:0] PEN_ZEROS  = 2'd1;
  localparam logic [1:0] PEN_INVERT = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [1:0] pen;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] cursor_page;
    logic [7:0] cursor_column;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col));
  endfunction

  function automatic logic [COL_W-1:0] col_add_sat(input logic [COL_W-1:0] col,
                                                   input int step);
    logic [COL_W:0] s;
    s = {1'b0, col} + (COL_W + 1)'(step);
    return (int'(s) > COLUMNS) ? COL_W'(COLUMNS) : COL_W'(s);
  endfunction

  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_WIDTH] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'hcf,8'hcf,8'h00,8'h00,8'h00},
    '{8'h00,8'h0c,8'h06,8'h00,8'h0c,8'h06,8'h00,8'h00},
    '{8'h24,8'he4,8'h3c,8'h27,8'he4,8'h3c,8'h27,8'h24},
    '{8'h00,8'h20,8'h46,8'hf9,8'h9f,8'h62,8'h04,8'h00},
    '{8'h06,8'h09,8'hc6,8'h30,8'h0c,8'h63,8'h90,8'h60},
    '{8'h00,8'h00,8'h6e,8'h91,8'ha9,8'h46,8'ha0,8'h00},
    '{8'h00,8'h00,8'h00,8'h1c,8'h0e,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h3c,8'h42,8'h81,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h81,8'h42,8'h3c,8'h00,8'h00},
    '{8'h00,8'h10,8'h54,8'h38,8'h38,8'h54,8'h10,8'h00},
    '{8'h00,8'h10,8'h10,8'hfc,8'h10,8'h10,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'hc0,8'h60,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h10,8'h10,8'h10,8'h10,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'hc0,8'hc0,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'hc0,8'h38,8'h07,8'h00,8'h00},
    '{8'h00,8'h00,8'h7c,8'h92,8'h8a,8'h7c,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h84,8'hfe,8'h80,8'h00,8'h00},
    '{8'h00,8'h00,8'h8c,8'hc2,8'ha2,8'h9c,8'h00,8'h00},
    '{8'h00,8'h00,8'h44,8'h92,8'h92,8'h6c,8'h00,8'h00},
    '{8'h00,8'h20,8'h38,8'h24,8'hfe,8'h20,8'h00,8'h00},
    '{8'h00,8'h00,8'h5e,8'h92,8'h92,8'h62,8'h00,8'h00},
    '{8'h00,8'h00,8'h78,8'h94,8'h92,8'h62,8'h00,8'h00},
    '{8'h00,8'h00,8'h82,8'h62,8'h1a,8'h06,8'h00,8'h00},
    '{8'h00,8'h00,8'h6c,8'h92,8'h92,8'h6c,8'h00,8'h00},
    '{8'h00,8'h00,8'h8c,8'h52,8'h32,8'h1c,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h6c,8'h6c,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h80,8'hec,8'h6c,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h10,8'h28,8'h44,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h24,8'h24,8'h24,8'h24,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h44,8'h28,8'h10,8'h00,8'h00},
    '{8'h00,8'h00,8'h0c,8'ha2,8'h92,8'h1c,8'h00,8'h00},
    '{8'h00,8'h3c,8'h42,8'h99,8'ha5,8'ha2,8'h3c,8'h00},
    '{8'h00,8'he0,8'h1c,8'h12,8'h12,8'h1c,8'he0,8'h00},
    '{8'h00,8'hfe,8'h92,8'h92,8'h9c,8'h90,8'h60,8'h00},
    '{8'h00,8'h38,8'h44,8'h82,8'h82,8'h82,8'h44,8'h00},
    '{8'h00,8'hfe,8'h82,8'h82,8'h82,8'h82,8'h7c,8'h00},
    '{8'h00,8'hfe,8'h92,8'h92,8'h92,8'h92,8'h92,8'h00},
    '{8'h00,8'hfe,8'h12,8'h12,8'h12,8'h12,8'h02,8'h00},
    '{8'h00,8'h7c,8'h82,8'h92,8'h92,8'h72,8'h00,8'h00},
    '{8'h00,8'hfe,8'h10,8'h10,8'h10,8'h10,8'hfe,8'h00},
    '{8'h00,8'h82,8'h82,8'hfe,8'h82,8'h82,8'h00,8'h00},
    '{8'h00,8'h82,8'h82,8'h7e,8'h02,8'h02,8'h00,8'h00},
    '{8'h00,8'hfe,8'h10,8'h28,8'h44,8'h82,8'h00,8'h00},
    '{8'h00,8'hfe,8'h80,8'h80,8'h80,8'h80,8'h00,8'h00},
    '{8'hfc,8'h02,8'h04,8'hf8,8'h04,8'h02,8'hfc,8'h00},
    '{8'h00,8'hfe,8'h04,8'h18,8'h30,8'h40,8'hfe,8'h00},
    '{8'h00,8'h7c,8'h82,8'h82,8'h82,8'h82,8'h7c,8'h00},
    '{8'h00,8'h00,8'hfe,8'h12,8'h12,8'h0c,8'h00,8'h00},
    '{8'h00,8'h00,8'h3c,8'h42,8'hc2,8'hbc,8'h00,8'h00},
    '{8'h00,8'h00,8'hfe,8'h32,8'h52,8'h8c,8'h00,8'h00},
    '{8'h00,8'h00,8'h4c,8'h92,8'h92,8'h64,8'h00,8'h00},
    '{8'h00,8'h02,8'h02,8'hfe,8'h02,8'h02,8'h00,8'h00},
    '{8'h00,8'h7e,8'h80,8'h80,8'h80,8'h80,8'h7e,8'h00},
    '{8'h00,8'h0c,8'h30,8'hc0,8'h30,8'h0c,8'h00,8'h00},
    '{8'h7c,8'h80,8'h80,8'h78,8'h80,8'h80,8'h7c,8'h00},
    '{8'h00,8'h84,8'h48,8'h30,8'h30,8'h48,8'h84,8'h00},
    '{8'h00,8'h06,8'h08,8'hf0,8'h08,8'h06,8'h00,8'h00},
    '{8'h00,8'h00,8'hc2,8'ha2,8'h92,8'h8e,8'h00,8'h00},
    '{8'h00,8'h00,8'hfe,8'h82,8'h82,8'h82,8'h00,8'h00},
    '{8'h00,8'h00,8'h06,8'h18,8'h60,8'h80,8'h00,8'h00},
    '{8'h00,8'h00,8'h82,8'h82,8'h82,8'hfe,8'h00,8'h00},
    '{8'h00,8'h30,8'h0c,8'h02,8'h0c,8'h30,8'h00,8'h00},
    '{8'h00,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h00},
    '{8'h00,8'h00,8'h04,8'h0c,8'h18,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h60,8'h90,8'h90,8'he0,8'h00,8'h00},
    '{8'h00,8'h00,8'hf8,8'ha0,8'he0,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h60,8'h90,8'h90,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'he0,8'ha0,8'hf8,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h70,8'ha8,8'ha8,8'h90,8'h00,8'h00},
    '{8'h00,8'h00,8'h10,8'hf8,8'h14,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'hd8,8'ha4,8'h7c,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'hf8,8'h20,8'he0,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'he8,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h40,8'h90,8'h74,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'hf8,8'h60,8'h90,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h78,8'h80,8'h80,8'h00,8'h00,8'h00},
    '{8'h00,8'he0,8'h10,8'he0,8'h10,8'he0,8'h00,8'h00},
    '{8'h00,8'h00,8'hf0,8'h10,8'h10,8'he0,8'h00,8'h00},
    '{8'h00,8'h00,8'h60,8'h90,8'h90,8'h60,8'h00,8'h00},
    '{8'h00,8'h00,8'hf0,8'h48,8'h48,8'h30,8'h00,8'h00},
    '{8'h00,8'h00,8'h30,8'h48,8'h48,8'hf0,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'hf0,8'h20,8'h10,8'h00,8'h00},
    '{8'h00,8'h00,8'h90,8'ha8,8'ha8,8'h48,8'h00,8'h00},
    '{8'h00,8'h10,8'h10,8'hf8,8'h90,8'h90,8'h00,8'h00},
    '{8'h00,8'h00,8'h78,8'h80,8'h80,8'hf8,8'h00,8'h00},
    '{8'h00,8'h18,8'h60,8'h80,8'h60,8'h18,8'h00,8'h00},
    '{8'h00,8'h38,8'hc0,8'h38,8'hc0,8'h38,8'h00,8'h00},
    '{8'h00,8'h88,8'h50,8'h20,8'h50,8'h88,8'h00,8'h00},
    '{8'h00,8'h8c,8'h50,8'h20,8'h10,8'h0c,8'h00,8'h00},
    '{8'h00,8'h88,8'hc8,8'ha8,8'h98,8'h88,8'h00,8'h00},
    '{8'h00,8'h00,8'h10,8'h7c,8'h82,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'hfe,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h82,8'h7c,8'h10,8'h00,8'h00}
  };

endpackage

`default_nettype wire

/* rtl/core/tcpr_frame_mem.sv */
// Frame store: one write port, one read port with registered read data.
// Depends on tcpr_pkg for sizes and the request struct.
`default_nettype none

module tcpr_frame_mem
  import tcpr_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output logic [7:0]    rdata
);

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcpr_seq.sv */
// Sequencer: cursor state, item decode, glyph writes and store sweeps.
// Depends on tcpr_pkg and text_console_page_renderer_assert.svh.
`default_nettype none

`include "text_console_page_renderer_assert.svh"

module tcpr_seq
  import tcpr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  output logic            cmd_stall,
  output logic            res_valid,
  output rsp_t            res,
  input  wire logic       res_ready,
  output mem_req_t        mem_req,
  input  wire logic [7:0] mem_rdata
);

  typedef enum logic [2:0] {ST_IDLE, ST_SWEEP, ST_GLYPH, ST_READ, ST_DONE} state_t;
  typedef enum logic [1:0] {SW_ONES, SW_ZEROS, SW_INVERT} sweep_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [GK_W-1:0]   LAST_K    = GK_W'(GLYPH_WIDTH - 1);

  state_t                 state;
  sweep_t                 sw_mode;
  logic [PAGE_W-1:0]      page;
  logic [COL_W-1:0]       col;
  logic [7:0]             read_data;
  logic [GLYPH_IDX_W-1:0] glyph_idx;
  logic [COL_W-1:0]       glyph_base;
  logic [GK_W-1:0]        glyph_k;
  logic [ADDR_W-1:0]      sw_rd;
  logic                   sw_rd_v;
  logic                   sw_wr_v;
  logic [ADDR_W-1:0]      sw_wr_addr;
  logic                   sw_report;
  logic                   sw_then_glyph;

  logic              is_nl, is_tab, is_glyph, col_wrap, ovf, rd_in_range;
  logic [PAGE_W-1:0] page_inc, p1, p2;
  logic [COL_W-1:0]  c1, c1_adv, tab_col;
  logic [COL_W:0]    gcol;

  always_comb begin
    is_nl       = cmd.char_code == 8'(CODE_NEWLINE);
    is_tab      = cmd.char_code == 8'(CODE_TAB);
    is_glyph    = cmd.char_code >= 8'(FIRST_GLYPH) && cmd.char_code < 8'(END_GLYPH);
    page_inc    = (int'(page) < PAGES) ? PAGE_W'(page + 1'b1) : page;
    col_wrap    = int'(col) >= COLUMNS;
    p1          = col_wrap ? page_inc : page;
    c1          = col_wrap ? '0 : col;
    ovf         = int'(p1) >= PAGES;
    p2          = ovf ? '0 : p1;
    c1_adv      = col_add_sat(c1, GLYPH_WIDTH);
    tab_col     = col_add_sat(col, TAB_STEP);
    rd_in_range = int'(cmd.read_page) < PAGES && int'(cmd.read_column) < COLUMNS;
    gcol        = {1'b0, glyph_base} + (COL_W + 1)'(glyph_k);
  end

  assign cmd_stall = state != ST_IDLE;
  assign res_valid = state == ST_DONE;
  assign res       = '{read_data: read_data, cursor_page: 4'(page), cursor_column: 8'(col)};

  always_comb begin
    mem_req = '0;
    unique case (state)
      ST_IDLE: begin
        mem_req.re    = cmd_valid && cmd.func == FUNC_READ && rd_in_range;
        mem_req.raddr = frame_addr(PAGE_W'(cmd.read_page), COL_W'(cmd.read_column));
      end
      ST_SWEEP: begin
        mem_req.re    = sw_rd_v;
        mem_req.raddr = sw_rd;
        mem_req.we    = sw_wr_v;
        mem_req.waddr = sw_wr_addr;
        case (sw_mode)
          SW_ONES:   mem_req.wdata = 8'hff;
          SW_INVERT: mem_req.wdata = ~mem_rdata;
          default:   mem_req.wdata = 8'h00;
        endcase
      end
      ST_GLYPH: begin
        mem_req.we    = int'(gcol) < COLUMNS;
        mem_req.waddr = frame_addr(page, COL_W'(gcol));
        mem_req.wdata = GLYPH_ROM[glyph_idx][glyph_k];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sw_mode       <= SW_ZEROS;
      sw_rd         <= '0;
      sw_rd_v       <= 1'b1;
      sw_wr_v       <= 1'b0;
      sw_report     <= 1'b0;
      sw_then_glyph <= 1'b0;
      page          <= '0;
      col           <= '0;
      read_data     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            read_data     <= '0;
            sw_rd         <= '0;
            sw_rd_v       <= 1'b1;
            sw_wr_v       <= 1'b0;
            sw_report     <= 1'b1;
            sw_then_glyph <= 1'b0;
            sw_mode       <= SW_ZEROS;
            state         <= ST_DONE;
            unique case (cmd.func)
              FUNC_PRINT: begin
                if (is_nl) begin
                  page <= page_inc;
                  col  <= '0;
                end else if (is_tab) begin
                  col <= tab_col;
                end else if (is_glyph) begin
                  page       <= p2;
                  col        <= c1_adv;
                  glyph_base <= c1;
                  glyph_idx  <= GLYPH_IDX_W'(cmd.char_code - 8'(FIRST_GLYPH));
                  glyph_k    <= '0;
                  if (ovf) begin
                    sw_then_glyph <= 1'b1;
                    state         <= ST_SWEEP;
                  end else begin
                    state <= ST_GLYPH;
                  end
                end
              end
              FUNC_FILL: begin
                case (cmd.pen)
                  PEN_ONES: begin
                    sw_mode <= SW_ONES;
                    state   <= ST_SWEEP;
                  end
                  PEN_ZEROS: begin
                    state <= ST_SWEEP;
                  end
                  PEN_INVERT: begin
                    sw_mode <= SW_INVERT;
                    state   <= ST_SWEEP;
                  end
                  default: begin
                  end
                endcase
              end
              FUNC_REWIND: begin
                page  <= '0;
                col   <= '0;
                state <= ST_SWEEP;
              end
              FUNC_READ: begin
                if (rd_in_range) begin
                  state <= ST_READ;
                end
              end
            endcase
          end
        end
        ST_SWEEP: begin
          sw_wr_v    <= sw_rd_v;
          sw_wr_addr <= sw_rd;
          if (sw_rd_v) begin
            if (sw_rd == LAST_ADDR) begin
              sw_rd_v <= 1'b0;
            end else begin
              sw_rd <= sw_rd + 1'b1;
            end
          end
          if (sw_wr_v && sw_wr_addr == LAST_ADDR) begin
            if (sw_then_glyph) begin
              state <= ST_GLYPH;
            end else if (sw_report) begin
              state <= ST_DONE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_GLYPH: begin
          glyph_k <= glyph_k + 1'b1;
          if (glyph_k == LAST_K) begin
            state <= ST_DONE;
          end
        end
        ST_READ: begin
          read_data <= mem_rdata;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TCPR_ASSERT_IMP(a_no_rw_clash, clk, rst, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr)
  `TCPR_ASSERT_NXT(a_accept_busy, clk, rst, cmd_valid && !cmd_stall, state != ST_IDLE)
  `TCPR_ASSERT_IMP(a_glyph_page, clk, rst, state == ST_GLYPH, int'(page) < PAGES)
  `TCPR_ASSERT_IMP(a_glyph_base, clk, rst, state == ST_GLYPH, int'(glyph_base) < COLUMNS)

endmodule

`default_nettype wire

/* rtl/core/text_console_page_renderer.sv */
// Text console page renderer, top level: sequencer, frame store, result register.
// Depends on tcpr_pkg, tcpr_seq and tcpr_frame_mem.
//
// Draws 8x8 glyphs into a PAGES x COLUMNS byte frame store and returns one
// result item (read byte and cursor) per command item. Items are handled one
// at a time by the sequencer around the single-port-write frame memory; a
// printed glyph takes one memory write per glyph byte that falls inside the page.
// Fill with a defined pen and rewind sweep the whole store one byte a cycle;
// a glyph that overflows the last page first runs the clearing sweep.
// After reset a clearing pass runs before the first item is taken.
// A result register lets the next item enter while a result waits on rsp_stall.
`default_nettype none

module text_console_page_renderer
  import tcpr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       res_valid;
  logic       res_ready;
  rsp_t       res;

  tcpr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  tcpr_frame_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for text_console_page_renderer: drives command items,
// predicts each result from a shadow frame store and cursor, and checks them.
// Depends on tcpr_pkg and the renderer RTL.
`default_nettype none

module tb_top;
  import tcpr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  text_console_page_renderer dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  cmd_t cmd_backlog[$];
  rsp_t rsp_due_q[$];
  logic [7:0] frame_img [STORE_BYTES];
  int cur_page;
  int cur_col;

  int cmd_total;
  int items_taken;
  int results_seen;
  int glyphs_drawn;
  int page_overflows;
  int reads_done;
  int sweeps_done;
  int mismatches;
  int cmd_gap;
  int rsp_hold;
  int rsp_wait;
  bit calm [2];

  // 0: command side, 1: result side; calm stretches give back-to-back traffic
  function automatic int pick_pause(input int side);
    if ($urandom_range(0, 31) == 0) calm[side] = !calm[side];
    return calm[side] ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic void wipe_frame();
    foreach (frame_img[i]) frame_img[i] = 8'h00;
  endfunction

  function automatic void advance_line();
    if (cur_page < PAGES) cur_page++;
    cur_col = 0;
  endfunction

  function automatic rsp_t render_item(input cmd_t c);
    rsp_t r;
    int k;
    int col;
    int code;
    r = '0;
    code = int'(c.char_code);
    case (c.func)
      FUNC_PRINT: begin
        if (code == CODE_NEWLINE) begin
          advance_line();
        end else if (code == CODE_TAB) begin
          cur_col = (cur_col + TAB_STEP > COLUMNS) ? COLUMNS : cur_col + TAB_STEP;
        end else if (code >= FIRST_GLYPH && code < END_GLYPH) begin
          if (cur_col >= COLUMNS) advance_line();
          if (cur_page >= PAGES) begin
            wipe_frame();
            cur_page = 0;
            page_overflows++;
          end
          for (k = 0; k < GLYPH_WIDTH; k++) begin
            col = cur_col + k;
            if (col < COLUMNS)
              frame_img[cur_page * COLUMNS + col] = GLYPH_ROM[code - FIRST_GLYPH][k];
          end
          cur_col = (cur_col + GLYPH_WIDTH > COLUMNS) ? COLUMNS : cur_col + GLYPH_WIDTH;
          glyphs_drawn++;
        end
      end
      FUNC_FILL: begin
        sweeps_done++;
        case (c.pen)
          PEN_ONES:   foreach (frame_img[i]) frame_img[i] = 8'hff;
          PEN_ZEROS:  wipe_frame();
          PEN_INVERT: foreach (frame_img[i]) frame_img[i] = ~frame_img[i];
          default: ;
        endcase
      end
      FUNC_REWIND: begin
        sweeps_done++;
        wipe_frame();
        cur_page = 0;
        cur_col = 0;
      end
      default: begin
        reads_done++;
        if (int'(c.read_page) < PAGES && int'(c.read_column) < COLUMNS)
          r.read_data = frame_img[int'(c.read_page) * COLUMNS + int'(c.read_column)];
      end
    endcase
    r.cursor_page = 4'(cur_page);
    r.cursor_column = 8'(cur_col);
    return r;
  endfunction

  function automatic void push_cmd(input logic [1:0] func, input int code, input int pen,
                                   input int page, input int col);
    cmd_t c;
    c.func = func;
    c.char_code = 8'(code);
    c.pen = 2'(pen);
    c.read_page = 3'(page);
    c.read_column = 7'(col);
    cmd_backlog.push_back(c);
  endfunction

  // mostly text with reads; rare fills and rewinds since each sweeps the store
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c = cmd_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      c.func = FUNC_PRINT;
      pick = $urandom_range(0, 99);
      if (pick < 75) c.char_code = 8'($urandom_range(FIRST_GLYPH, END_GLYPH - 1));
      else if (pick < 87) c.char_code = 8'(CODE_NEWLINE);
      else if (pick < 93) c.char_code = 8'(CODE_TAB);
      else if (pick < 96) c.char_code = 8'($urandom_range(0, FIRST_GLYPH - 1));
      else c.char_code = 8'($urandom_range(END_GLYPH, 255));
    end else if (pick < 95) begin
      c.func = FUNC_READ;
    end else if (pick < 99) begin
      c.func = FUNC_FILL;
    end else begin
      c.func = FUNC_REWIND;
    end
    return c;
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd_gap <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        rsp_due_q.push_back(render_item(cmd));
        items_taken++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_gap > 0) begin
          cmd_valid <= 1'b0;
          cmd_gap <= cmd_gap - 1;
        end else if (cmd_backlog.size() > 0) begin
          cmd <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
          cmd_gap <= pick_pause(0);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_hold <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      results_seen++;
      if (rsp_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: read_data %h page %0d column %0d",
                   rsp.read_data, rsp.cursor_page, rsp.cursor_column);
      end else begin
        rsp_t e;
        e = rsp_due_q.pop_front();
        if (rsp.read_data !== e.read_data || rsp.cursor_page !== e.cursor_page ||
            rsp.cursor_column !== e.cursor_column) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: read_data %h/%h page %0d/%0d column %0d/%0d",
                     results_seen, e.read_data, rsp.read_data, e.cursor_page,
                     rsp.cursor_page, e.cursor_column, rsp.cursor_column);
        end
      end
      rsp_wait = pick_pause(1);
      rsp_stall <= (rsp_wait != 0);
      rsp_hold <= (rsp_wait != 0) ? rsp_wait - 1 : 0;
    end else if (rsp_hold > 0) begin
      rsp_stall <= 1'b1;
      rsp_hold <= rsp_hold - 1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  initial begin
    int n;
    int j;
    cur_page = 0;
    cur_col = 0;
    wipe_frame();

    // directed: glyph range edges, ignored codes, every fill pen, rewind, reads
    push_cmd(FUNC_READ, 0, 0, 0, 0);
    push_cmd(FUNC_PRINT, 65, 0, 0, 0);
    push_cmd(FUNC_PRINT, FIRST_GLYPH, 0, 0, 0);
    push_cmd(FUNC_PRINT, END_GLYPH - 1, 0, 0, 0);
    push_cmd(FUNC_PRINT, END_GLYPH, 0, 0, 0);
    push_cmd(FUNC_PRINT, 255, 0, 0, 0);
    push_cmd(FUNC_PRINT, 0, 0, 0, 0);
    push_cmd(FUNC_PRINT, FIRST_GLYPH - 1, 0, 0, 0);
    push_cmd(FUNC_READ, 0, 0, 0, 3);
    push_cmd(FUNC_READ, 0, 0, 0, 19);
    push_cmd(FUNC_PRINT, CODE_TAB, 0, 0, 0);
    push_cmd(FUNC_PRINT, CODE_NEWLINE, 0, 0, 0);
    push_cmd(FUNC_PRINT, 33, 0, 0, 0);
    push_cmd(FUNC_FILL, 0, PEN_ONES, 0, 0);
    push_cmd(FUNC_READ, 0, 0, 7, 127);
    push_cmd(FUNC_FILL, 0, PEN_INVERT, 0, 0);
    push_cmd(FUNC_READ, 0, 0, 1, 4);
    push_cmd(FUNC_PRINT, 90, 0, 0, 0);
    push_cmd(FUNC_FILL, 0, PEN_INVERT, 0, 0);
    push_cmd(FUNC_READ, 0, 0, 1, 11);
    push_cmd(FUNC_FILL, 0, 3, 0, 0);
    push_cmd(FUNC_READ, 0, 0, 1, 11);
    push_cmd(FUNC_FILL, 0, PEN_ZEROS, 0, 0);
    push_cmd(FUNC_REWIND, 0, 0, 0, 0);
    push_cmd(FUNC_READ, 0, 0, 7, 127);

    n = 0;
    while (n < 950) begin
      if ($urandom_range(0, 59) == 0) begin
        // run the page past the bottom, then draw to force the overflow clear
        for (j = 0; j < PAGES + 1; j++) push_cmd(FUNC_PRINT, CODE_NEWLINE, 0, 0, 0);
        push_cmd(FUNC_PRINT, $urandom_range(FIRST_GLYPH, END_GLYPH - 1), 0, 0, 0);
        n += PAGES + 2;
      end else begin
        cmd_backlog.push_back(random_cmd());
        n++;
      end
    end
    cmd_total = cmd_backlog.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (items_taken < cmd_total) @(posedge clk);
    while (rsp_due_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d items: %0d glyphs drawn, %0d page overflows, %0d reads, %0d store sweeps",
             items_taken, glyphs_drawn, page_overflows, reads_done, sweeps_done);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && rsp_due_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout: %0d of %0d items taken, %0d results pending",
             items_taken, cmd_total, rsp_due_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
